// ===== sv/rfp_pkg.sv =====
// Shared types, constants and command table for the rangefinder frame parser.
package rfp_pkg;

  typedef enum logic [1:0] {
    KIND_DIST = 2'd0,
    KIND_ERR  = 2'd1,
    KIND_CMD  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] data;
  } job_t;

  localparam logic [7:0]  HDR_DIST      = 8'hAA;
  localparam logic [7:0]  HDR_ERR       = 8'hEE;
  localparam logic [7:0]  DIST_BYTE2    = 8'h00;
  localparam logic [7:0]  DIST_BYTE3    = 8'h22;
  localparam logic [3:0]  POS_HUNT      = 4'd0;
  localparam logic [3:0]  POS_FIRST     = 4'd1;
  localparam logic [3:0]  POS_CHECK2    = 4'd2;
  localparam logic [3:0]  POS_CHECK3    = 4'd3;
  localparam logic [3:0]  POS_DIST_LO   = 4'd6;
  localparam logic [3:0]  POS_DIST_HI   = 4'd9;
  localparam logic [3:0]  POS_DIST_END  = 4'd12;
  localparam logic [3:0]  POS_ERR_LO    = 4'd6;
  localparam logic [3:0]  POS_ERR_HI    = 4'd7;
  localparam logic [3:0]  POS_ERR_END   = 4'd8;
  localparam logic [16:0] TICK_MAX      = 17'h1FFFF;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [3:0]  CMD_LAST      = 4'd8;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Continuous-measurement request: AA 00 00 20 00 01 00 04 25
  function automatic logic [7:0] cmd_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'hAA;
      4'd3:    b = 8'h20;
      4'd5:    b = 8'h01;
      4'd7:    b = 8'h04;
      4'd8:    b = 8'h25;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== sv/rfp_front.sv =====
// Front end: byte hunting, frame field capture, tick timeout and job generation.
module rfp_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_wr_en,
  input  logic [15:0]    cfg_wr_data,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           operation,
  input  logic [7:0]     rx_byte,
  input  logic           queue_full,
  output logic           push,
  output rfp_pkg::job_t  push_job
);

  logic        accept;
  logic [15:0] timeout_ms;
  logic [3:0]  pos, pos_next;
  logic        is_err, is_err_next;
  logic [31:0] dshift, dshift_next;
  logic [15:0] eshift, eshift_next;
  logic [16:0] elapsed, elapsed_next;
  logic [16:0] tick_inc;
  logic        hdr_dist, hdr_err, hunt, bad_byte;

  assign in_stall = queue_full;
  assign accept   = in_valid && !queue_full;
  assign hdr_dist = (rx_byte == rfp_pkg::HDR_DIST);
  assign hdr_err  = (rx_byte == rfp_pkg::HDR_ERR);
  assign tick_inc = (elapsed == rfp_pkg::TICK_MAX) ? elapsed : elapsed + 17'd1;
  assign bad_byte = ((pos == rfp_pkg::POS_CHECK2) && (rx_byte != rfp_pkg::DIST_BYTE2)) ||
                    ((pos == rfp_pkg::POS_CHECK3) && (rx_byte != rfp_pkg::DIST_BYTE3));

  always_comb begin
    pos_next      = pos;
    is_err_next   = is_err;
    dshift_next   = dshift;
    eshift_next   = eshift;
    elapsed_next  = elapsed;
    push          = 1'b0;
    push_job.kind = rfp_pkg::KIND_DIST;
    push_job.data = '0;
    hunt          = 1'b0;
    if (accept) begin
      if (operation) begin
        if (tick_inc > {1'b0, timeout_ms}) begin
          elapsed_next  = '0;
          push          = 1'b1;
          push_job.kind = rfp_pkg::KIND_CMD;
        end else begin
          elapsed_next = tick_inc;
        end
      end else if (pos == rfp_pkg::POS_HUNT) begin
        hunt = 1'b1;
      end else if (!is_err) begin
        if (bad_byte) begin
          hunt = 1'b1;
        end else begin
          if (pos >= rfp_pkg::POS_DIST_LO && pos <= rfp_pkg::POS_DIST_HI) begin
            dshift_next = {dshift[23:0], rx_byte};
          end
          if (pos == rfp_pkg::POS_DIST_END) begin
            pos_next      = rfp_pkg::POS_HUNT;
            elapsed_next  = '0;
            push          = 1'b1;
            push_job.kind = rfp_pkg::KIND_DIST;
            push_job.data = dshift_next;
          end else begin
            pos_next = pos + 4'd1;
          end
        end
      end else begin
        if (pos == rfp_pkg::POS_ERR_LO || pos == rfp_pkg::POS_ERR_HI) begin
          eshift_next = {eshift[7:0], rx_byte};
        end
        if (pos == rfp_pkg::POS_ERR_END) begin
          pos_next      = rfp_pkg::POS_HUNT;
          push          = 1'b1;
          push_job.kind = rfp_pkg::KIND_ERR;
          push_job.data = {16'd0, eshift_next};
        end else begin
          pos_next = pos + 4'd1;
        end
      end
      if (hunt) begin
        if (hdr_dist || hdr_err) begin
          pos_next    = rfp_pkg::POS_FIRST;
          is_err_next = hdr_err;
        end else begin
          pos_next = rfp_pkg::POS_HUNT;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms <= rfp_pkg::TIMEOUT_RESET;
      pos        <= rfp_pkg::POS_HUNT;
      is_err     <= 1'b0;
      dshift     <= '0;
      eshift     <= '0;
      elapsed    <= rfp_pkg::TICK_MAX;
    end else begin
      if (cfg_wr_en) begin
        timeout_ms <= cfg_wr_data;
      end
      pos     <= pos_next;
      is_err  <= is_err_next;
      dshift  <= dshift_next;
      eshift  <= eshift_next;
      elapsed <= elapsed_next;
    end
  end

endmodule

// ===== sv/rfp_queue.sv =====
// Small job queue between the front end and the output stage.
module rfp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rfp_pkg::job_t  push_job,
  input  logic           pop,
  output logic           full,
  output logic           empty,
  output rfp_pkg::job_t  head
);

  rfp_pkg::job_t                  mem [rfp_pkg::QUEUE_DEPTH];
  logic [rfp_pkg::QPTR_W-1:0]     wptr, rptr;
  logic [rfp_pkg::QCNT_W-1:0]     count;

  assign full  = (count == rfp_pkg::QCNT_W'(rfp_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/rfp_back.sv =====
// Output stage: turns queued jobs into result transactions, expanding requests.
module rfp_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  rfp_pkg::job_t  q_head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [1:0]     kind,
  output logic [31:0]    distance,
  output logic [15:0]    error_code,
  output logic [7:0]     tx_byte,
  output logic           last
);

  rfp_pkg::kind_t okind;
  logic [3:0]     cidx, cidx_next;
  logic           advance, cmd_cont;

  assign advance  = !out_valid || !out_stall;
  assign cmd_cont = out_valid && (okind == rfp_pkg::KIND_CMD) && !last;
  assign pop      = advance && !cmd_cont && !q_empty;
  assign kind     = okind;
  assign cidx_next = cmd_cont ? cidx + 4'd1 : 4'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      okind     <= rfp_pkg::KIND_DIST;
      last      <= 1'b0;
      cidx      <= '0;
    end else if (advance) begin
      if (cmd_cont || pop) begin
        out_valid <= 1'b1;
        cidx      <= cidx_next;
        if (cmd_cont || q_head.kind == rfp_pkg::KIND_CMD) begin
          okind <= rfp_pkg::KIND_CMD;
          last  <= (cidx_next == rfp_pkg::CMD_LAST);
        end else begin
          okind <= q_head.kind;
          last  <= 1'b1;
        end
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && (cmd_cont || pop)) begin
      if (cmd_cont || q_head.kind == rfp_pkg::KIND_CMD) begin
        distance   <= '0;
        error_code <= '0;
        tx_byte    <= rfp_pkg::cmd_byte(cidx_next);
      end else if (q_head.kind == rfp_pkg::KIND_DIST) begin
        distance   <= q_head.data;
        error_code <= '0;
        tx_byte    <= '0;
      end else begin
        distance   <= '0;
        error_code <= q_head.data[15:0];
        tx_byte    <= '0;
      end
    end
  end

endmodule

// ===== sv/rangefinder_frame_parser.sv =====
// Top level of the serial rangefinder frame parser.
// Input channel (in_valid/in_stall): operation 0 carries a received serial
// byte in rx_byte, operation 1 is a one millisecond tick. One transaction can
// be taken every cycle while the four-entry job queue has room; in_stall is
// high only when that queue is full.
// Output channel (out_valid/out_stall): kind 0 reports a distance frame,
// kind 1 an error frame, kind 2 one byte of the nine-byte measurement request
// to transmit. last marks the final result caused by one input.
// A result is presented after its input passes through the job queue and the
// output register. A frame gives one result; a request gives nine consecutive
// results, so sustained rate is one result per cycle while out_stall is low,
// and the request expansion in the output stage sets the worst case.
// While out_stall is high the output register holds; the front end keeps
// taking input until the queue fills.
// cfg_wr_en/cfg_wr_data write timeout_ms, to be written only while idle.
// Reset (rst, synchronous) empties the queue, restarts header hunting, sets
// timeout_ms to 1000 and saturates the tick count so the first tick requests.
module rangefinder_frame_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [31:0] distance,
  output logic [15:0] error_code,
  output logic [7:0]  tx_byte,
  output logic        last
);

  logic          push, pop, q_full, q_empty;
  rfp_pkg::job_t push_job, q_head;

  rfp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .rx_byte     (rx_byte),
    .queue_full  (q_full),
    .push        (push),
    .push_job    (push_job)
  );

  rfp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  rfp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .distance   (distance),
    .error_code (error_code),
    .tx_byte    (tx_byte),
    .last       (last)
  );

endmodule

// ===== sv/rfp_checker.sv =====
// Port-level checker for the rangefinder frame parser, bound to the top level.
module rfp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  kind,
  input logic [31:0] distance,
  input logic [15:0] error_code,
  input logic [7:0]  tx_byte,
  input logic        last
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(distance) &&
      $stable(error_code) && $stable(tx_byte) && $stable(last))
    else $error("output changed while stalled");

  a_frame_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == rfp_pkg::KIND_DIST || kind == rfp_pkg::KIND_ERR) |-> last)
    else $error("frame result not marked last");

  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind == rfp_pkg::KIND_CMD || tx_byte == 8'd0) &&
      (kind == rfp_pkg::KIND_DIST || distance == 32'd0) &&
      (kind == rfp_pkg::KIND_ERR || error_code == 16'd0))
    else $error("unused result field not zero");

  a_cmd_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && kind == rfp_pkg::KIND_CMD && !last |=>
      out_valid && kind == rfp_pkg::KIND_CMD)
    else $error("request burst interrupted");

  a_reset_idle: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid && !in_stall)
    else $error("not idle after reset");

endmodule

bind rangefinder_frame_parser rfp_checker u_rfp_checker (.*);

// ===== sim/testbench.sv =====
// Self-checking testbench for the rangefinder frame parser: random frames, ticks and stalls.
`timescale 1ns / 1ps

module testbench;

  localparam int DRAIN_CYCLES = 24;
  localparam int PHASE_ITEMS  = 68;

  typedef struct {
    rfp_pkg::kind_t kind;
    logic [31:0]    distance;
    logic [15:0]    error_code;
    logic [7:0]     tx_byte;
    logic           last;
  } report_t;

  class frame_scoreboard;
    logic [7:0]  request_bytes [9] = '{8'hAA, 8'h00, 8'h00, 8'h20, 8'h00,
                                       8'h01, 8'h00, 8'h04, 8'h25};
    report_t     expected_reports [$];
    logic [15:0] timeout_ms = rfp_pkg::TIMEOUT_RESET;
    logic [3:0]  position = rfp_pkg::POS_HUNT;
    logic        in_error_frame = 1'b0;
    logic [31:0] distance_acc = '0;
    logic [15:0] error_acc = '0;
    logic [16:0] ticks = rfp_pkg::TICK_MAX;
    int          fails = 0;

    function void set_timeout(logic [15:0] value);
      timeout_ms = value;
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    function void push_report(rfp_pkg::kind_t k, logic [31:0] d, logic [15:0] e,
                              logic [7:0] t, logic l);
      report_t r;
      r.kind = k;
      r.distance = d;
      r.error_code = e;
      r.tx_byte = t;
      r.last = l;
      expected_reports.push_back(r);
    endfunction

    function void hunt_header(logic [7:0] b);
      if (b == rfp_pkg::HDR_DIST) begin
        in_error_frame = 1'b0;
        position = rfp_pkg::POS_FIRST;
      end else if (b == rfp_pkg::HDR_ERR) begin
        in_error_frame = 1'b1;
        position = rfp_pkg::POS_FIRST;
      end else begin
        position = rfp_pkg::POS_HUNT;
      end
    endfunction

    function void accept_input(logic op, logic [7:0] b);
      if (op) begin
        if (ticks != rfp_pkg::TICK_MAX) ticks++;
        if (ticks > {1'b0, timeout_ms}) begin
          ticks = '0;
          for (int i = 0; i < 9; i++)
            push_report(rfp_pkg::KIND_CMD, '0, '0, request_bytes[i], i == 8);
        end
        return;
      end
      if (position == rfp_pkg::POS_HUNT) begin
        hunt_header(b);
        return;
      end
      if (!in_error_frame) begin
        if ((position == rfp_pkg::POS_CHECK2 && b != rfp_pkg::DIST_BYTE2) ||
            (position == rfp_pkg::POS_CHECK3 && b != rfp_pkg::DIST_BYTE3)) begin
          hunt_header(b);
          return;
        end
        if (position >= rfp_pkg::POS_DIST_LO && position <= rfp_pkg::POS_DIST_HI)
          distance_acc = {distance_acc[23:0], b};
        if (position == rfp_pkg::POS_DIST_END) begin
          position = rfp_pkg::POS_HUNT;
          ticks = '0;
          push_report(rfp_pkg::KIND_DIST, distance_acc, '0, '0, 1'b1);
          return;
        end
      end else begin
        if (position == rfp_pkg::POS_ERR_LO || position == rfp_pkg::POS_ERR_HI)
          error_acc = {error_acc[7:0], b};
        if (position == rfp_pkg::POS_ERR_END) begin
          position = rfp_pkg::POS_HUNT;
          push_report(rfp_pkg::KIND_ERR, '0, error_acc, '0, 1'b1);
          return;
        end
      end
      position = position + 4'd1;
    endfunction

    function void compare_field(string name, logic [31:0] exp_val, logic [31:0] got_val);
      if (got_val !== exp_val) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, got_val);
        fails++;
      end
    endfunction

    function void check_report(report_t got);
      report_t exp_r;
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected result, kind %0d distance %0h error_code %0h tx_byte %0h",
                 $time, got.kind, got.distance, got.error_code, got.tx_byte);
        fails++;
        return;
      end
      exp_r = expected_reports.pop_front();
      compare_field("kind", 32'(exp_r.kind), 32'(got.kind));
      compare_field("distance", exp_r.distance, got.distance);
      compare_field("error_code", 32'(exp_r.error_code), 32'(got.error_code));
      compare_field("tx_byte", 32'(exp_r.tx_byte), 32'(got.tx_byte));
      compare_field("last", 32'(exp_r.last), 32'(got.last));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        operation = 1'b0;
  logic [7:0]  rx_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic [31:0] distance;
  logic [15:0] error_code;
  logic [7:0]  tx_byte;
  logic        last;

  frame_scoreboard sb = new();
  bit sink_quiet = 1'b0;
  bit source_burst = 1'b0;
  int stall_hold = 0;
  int stall_roll;

  rangefinder_frame_parser DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .distance    (distance),
    .error_code  (error_code),
    .tx_byte     (tx_byte),
    .last        (last)
  );

  always #4 clk = ~clk;

  // receiver back-pressure: mostly short stalls, a few long ones
  always @(posedge clk) begin
    if (rst || sink_quiet) begin
      out_stall <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold != 0) begin
      out_stall <= 1'b1;
      stall_hold <= stall_hold - 1;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 20) begin
        out_stall <= 1'b1;
        stall_hold <= (stall_roll < 2) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    report_t got;
    if (!rst && out_valid && !out_stall) begin
      got.kind = rfp_pkg::kind_t'(kind);
      got.distance = distance;
      got.error_code = error_code;
      got.tx_byte = tx_byte;
      got.last = last;
      sb.check_report(got);
    end
  end

  function automatic logic [7:0] noise_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] wrong_byte(logic [7:0] good);
    logic [7:0] b;
    case ($urandom_range(0, 3))
      0: b = rfp_pkg::HDR_DIST;
      1: b = rfp_pkg::HDR_ERR;
      default: begin
        do b = noise_byte(); while (b == good);
      end
    endcase
    return b;
  endfunction

  task automatic send_item(input logic op, input logic [7:0] b);
    int gap;
    int roll;
    roll = $urandom_range(0, 99);
    if (source_burst || roll < 60) gap = 0;
    else if (roll < 90) gap = $urandom_range(1, 3);
    else if (roll < 98) gap = $urandom_range(4, 10);
    else gap = $urandom_range(20, 60);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    rx_byte <= b;
    do @(posedge clk); while (in_stall);
    sb.accept_input(op, b);
  endtask

  task automatic send_distance_frame(input logic [31:0] d);
    send_item(1'b0, rfp_pkg::HDR_DIST);
    send_item(1'b0, noise_byte());
    send_item(1'b0, rfp_pkg::DIST_BYTE2);
    send_item(1'b0, rfp_pkg::DIST_BYTE3);
    repeat (2) send_item(1'b0, noise_byte());
    for (int i = 3; i >= 0; i--) send_item(1'b0, d[8*i +: 8]);
    repeat (3) send_item(1'b0, noise_byte());
  endtask

  task automatic send_error_frame(input logic [15:0] code);
    send_item(1'b0, rfp_pkg::HDR_ERR);
    repeat (5) send_item(1'b0, noise_byte());
    send_item(1'b0, code[15:8]);
    send_item(1'b0, code[7:0]);
    send_item(1'b0, noise_byte());
  endtask

  task automatic wait_drained();
    bit hold;
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    hold = sink_quiet;
    sink_quiet = 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk);
    sink_quiet = hold;
  endtask

  task automatic write_timeout(input logic [15:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    sb.set_timeout(value);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [15:0] timeouts [6];
    int phase_items;
    int roll;
    int n;
    logic [31:0] d;

    timeouts = '{16'd0, 16'd1, 16'd65535, 16'd3, 16'($urandom_range(2, 50)),
                 16'($urandom_range(1, 65535))};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: first tick requests, stray byte, bad byte 2 and 3, re-hunted header
    send_item(1'b1, noise_byte());
    send_item(1'b0, 8'h55);
    send_item(1'b0, rfp_pkg::HDR_DIST);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'h01);
    send_item(1'b0, rfp_pkg::HDR_DIST);
    send_item(1'b0, 8'h00);
    send_item(1'b0, rfp_pkg::DIST_BYTE2);
    send_item(1'b0, 8'h21);
    send_item(1'b0, rfp_pkg::HDR_DIST);
    send_item(1'b0, 8'h00);
    send_item(1'b0, rfp_pkg::HDR_ERR);
    repeat (5) send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'h00);
    send_distance_frame(32'hFFFF_FFFF);

    foreach (timeouts[p]) begin
      wait_drained();
      write_timeout(timeouts[p]);
      sink_quiet = ($urandom_range(0, 3) == 0);
      source_burst = ($urandom_range(0, 3) == 0);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
          case ($urandom_range(0, 9))
            0: d = '0;
            1: d = '1;
            default: d = $urandom;
          endcase
          send_distance_frame(d);
          phase_items += 13;
        end else if (roll < 60) begin
          case ($urandom_range(0, 9))
            0: send_error_frame('0);
            1: send_error_frame('1);
            default: send_error_frame(16'($urandom_range(0, 65535)));
          endcase
          phase_items += 9;
        end else if (roll < 78) begin
          n = $urandom_range(1, 4);
          repeat (n) send_item(1'b1, noise_byte());
          phase_items += n;
        end else if (roll < 88) begin
          send_item(1'b0, rfp_pkg::HDR_DIST);
          send_item(1'b0, noise_byte());
          if ($urandom_range(0, 1)) begin
            send_item(1'b0, wrong_byte(rfp_pkg::DIST_BYTE2));
            phase_items += 3;
          end else begin
            send_item(1'b0, rfp_pkg::DIST_BYTE2);
            send_item(1'b0, wrong_byte(rfp_pkg::DIST_BYTE3));
            phase_items += 4;
          end
        end else begin
          n = $urandom_range(1, 3);
          repeat (n) send_item(1'b0, noise_byte());
          phase_items += n;
        end
      end
    end

    sink_quiet = 1'b0;
    wait_drained();
    if (sb.fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
